### rtl/core/positional_sequence_store_top_assert.svh
// Assertion macros for the positional sequence store.
// Used by positional_sequence_store_top.sv; no other dependencies.
`ifndef POSITIONAL_SEQUENCE_STORE_TOP_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pss_pkg.sv
// Shared types and codes for the positional sequence store.
// Used by pss_ctrl, pss_datapath and the top level; depends on nothing.
package pss_pkg;

    typedef enum logic [2:0] {
        ACT_INS_AT    = 3'd0,
        ACT_INS_FRONT = 3'd1,
        ACT_INS_BACK  = 3'd2,
        ACT_DEL_AT    = 3'd3,
        ACT_DEL_FRONT = 3'd4,
        ACT_DEL_BACK  = 3'd5,
        ACT_READ_AT   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_INS  = 2'd1,
        K_DEL  = 2'd2,
        K_RD   = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a new item
        logic rd_take;  // read the word at the item's position
        logic capture;  // keep the read word as the result
        logic rd_move;  // read the neighbor of the move index
        logic wr_move;  // write the read word at the move index, step the index
        logic wr_put;   // write the new word at the item's position
        logic finish;   // update the count and present the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  err;     // item is flagged, store is left alone
        logic  more;    // another word has to be moved
    } t_dp_stat;

endpackage

### rtl/core/pss_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/pss_ctrl.sv
// Controller state machine for the positional sequence store.
// Depends on pss_pkg; drives the command struct of pss_datapath.
module pss_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  pss_pkg::t_dp_stat  i_stat,
    output pss_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE_CAP,
        S_LOOP,
        S_MOVE_WR,
        S_PUT,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.err || i_stat.kind == pss_pkg::K_NONE) begin
                    n_state = S_FINISH;
                end else if (i_stat.kind == pss_pkg::K_INS) begin
                    n_state = S_LOOP;
                end else begin
                    o_cmd.rd_take = 1'b1;
                    n_state       = S_TAKE_CAP;
                end
            end
            S_TAKE_CAP: begin
                o_cmd.capture = 1'b1;
                n_state = (i_stat.kind == pss_pkg::K_DEL) ? S_LOOP : S_FINISH;
            end
            S_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd_move = 1'b1;
                    n_state       = S_MOVE_WR;
                end else if (i_stat.kind == pss_pkg::K_INS) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MOVE_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_LOOP;
            end
            S_PUT: begin
                o_cmd.wr_put = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

### rtl/core/pss_datapath.sv
// Datapath of the positional sequence store: count, item registers, word RAM,
// move index and result registers. Depends on pss_pkg and pss_ram.
module pss_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_action,
    input  logic [4:0]        i_position,
    input  logic [31:0]       i_value,
    input  pss_pkg::t_dp_cmd  i_cmd,
    output pss_pkg::t_dp_stat o_stat,
    output logic              o_strobe,
    output logic [31:0]       o_read_value,
    output logic [1:0]        o_status,
    output logic [4:0]        o_element_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int VW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    // control state
    logic [CW-1:0]    r_count, n_count;
    pss_pkg::t_kind   r_kind;
    pss_pkg::t_status r_status;
    logic             r_strobe;

    // payload
    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_idx;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] r_result;
    logic [31:0]           r_read_value;
    logic [1:0]            r_status_out;
    logic [4:0]            r_count_out;

    // request decode
    logic [CMPW-1:0]  pos_ext, cnt_ext, depth_ext, eff_pos, n_count_ext;
    pss_pkg::t_kind   dec_kind;
    pss_pkg::t_status dec_status;
    logic             is_full, is_empty;
    logic [VW-1:0]    value_ext, result_ext;

    // RAM side
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    assign pos_ext   = CMPW'(i_position);
    assign cnt_ext   = CMPW'(r_count);
    assign depth_ext = CMPW'(DEPTH);
    assign is_full   = (cnt_ext >= depth_ext);
    assign is_empty  = (r_count == '0);
    assign value_ext = VW'(i_value);

    always_comb begin
        dec_kind   = pss_pkg::K_NONE;
        dec_status = pss_pkg::ST_OK;
        eff_pos    = '0;
        unique case (pss_pkg::t_action'(i_action))
            pss_pkg::ACT_INS_AT: begin
                dec_kind = pss_pkg::K_INS;
                eff_pos  = pos_ext;
                if (is_full) dec_status = pss_pkg::ST_FULL;
                else if (pos_ext > cnt_ext) dec_status = pss_pkg::ST_BAD_POS;
            end
            pss_pkg::ACT_INS_FRONT: begin
                dec_kind = pss_pkg::K_INS;
                if (is_full) dec_status = pss_pkg::ST_FULL;
            end
            pss_pkg::ACT_INS_BACK: begin
                dec_kind = pss_pkg::K_INS;
                eff_pos  = cnt_ext;
                if (is_full) dec_status = pss_pkg::ST_FULL;
            end
            pss_pkg::ACT_DEL_AT: begin
                dec_kind = pss_pkg::K_DEL;
                eff_pos  = pos_ext;
                if (is_empty) dec_status = pss_pkg::ST_EMPTY;
                else if (pos_ext >= cnt_ext) dec_status = pss_pkg::ST_BAD_POS;
            end
            pss_pkg::ACT_DEL_FRONT: begin
                dec_kind = pss_pkg::K_DEL;
                if (is_empty) dec_status = pss_pkg::ST_EMPTY;
            end
            pss_pkg::ACT_DEL_BACK: begin
                dec_kind = pss_pkg::K_DEL;
                eff_pos  = cnt_ext - CMPW'(1);
                if (is_empty) dec_status = pss_pkg::ST_EMPTY;
            end
            pss_pkg::ACT_READ_AT: begin
                dec_kind = pss_pkg::K_RD;
                eff_pos  = pos_ext;
                if (pos_ext >= cnt_ext) dec_status = pss_pkg::ST_BAD_POS;
            end
            default: begin
                dec_kind = pss_pkg::K_NONE;
            end
        endcase
    end

    // status toward the controller
    always_comb begin
        o_stat.kind = r_kind;
        o_stat.err  = (r_status != pss_pkg::ST_OK);
        unique case (r_kind)
            pss_pkg::K_INS: o_stat.more = (r_idx > r_pos);
            pss_pkg::K_DEL: o_stat.more = ((CW'(r_idx) + CW'(1)) < r_count);
            default:        o_stat.more = 1'b0;
        endcase
    end

    // RAM access: insert moves walk toward the item's position, delete moves away
    assign ram_re    = i_cmd.rd_take | i_cmd.rd_move;
    assign ram_raddr = i_cmd.rd_take ? r_pos :
                       ((r_kind == pss_pkg::K_DEL) ? r_idx + AW'(1) : r_idx - AW'(1));
    assign ram_we    = i_cmd.wr_move | i_cmd.wr_put;
    assign ram_waddr = i_cmd.wr_put ? r_pos : r_idx;
    assign ram_wdata = i_cmd.wr_put ? r_value : ram_rdata;

    pss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count = r_count;
        if (r_status == pss_pkg::ST_OK) begin
            if (r_kind == pss_pkg::K_INS) n_count = r_count + CW'(1);
            else if (r_kind == pss_pkg::K_DEL) n_count = r_count - CW'(1);
        end
    end

    assign n_count_ext = CMPW'(n_count);
    assign result_ext  = VW'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_kind   <= pss_pkg::K_NONE;
            r_status <= pss_pkg::ST_OK;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.load) begin
                r_kind   <= dec_kind;
                r_status <= dec_status;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos    <= eff_pos[AW-1:0];
            r_idx    <= (dec_kind == pss_pkg::K_INS) ? cnt_ext[AW-1:0] : eff_pos[AW-1:0];
            r_value  <= value_ext[DATA_WIDTH-1:0];
            r_result <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_result <= ram_rdata;
            end
            if (i_cmd.wr_move) begin
                r_idx <= (r_kind == pss_pkg::K_DEL) ? r_idx + AW'(1) : r_idx - AW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_read_value <= result_ext[31:0];
            r_status_out <= r_status;
            r_count_out  <= n_count_ext[4:0];
        end
    end

    assign o_strobe        = r_strobe;
    assign o_read_value    = r_read_value;
    assign o_status        = r_status_out;
    assign o_element_count = r_count_out;

endmodule

### rtl/core/positional_sequence_store_top.sv
// Top level of the positional sequence store: controller plus datapath.
// Depends on pss_pkg, pss_ctrl, pss_datapath (with pss_ram) and the assert header.
//
//  channel   handshake             payload
//  --------  --------------------  ------------------------------------------
//  request   start, busy           i_action, i_position, i_value
//  result    o_strobe (one cycle)  o_read_value, o_status, o_element_count
//
// An item is taken on a clock edge with start high and busy low. Busy then
// stays high until the item is done: a flagged item or an unused action only
// finishes, a read takes its word, an insert or delete moves the words behind
// the position. Each moved word costs one RAM read and one RAM write on
// separate cycles. The result strobes for one cycle as busy falls; a new item
// may be taken in that same cycle. Results cannot be held off by the receiver.
// Synchronous active-low reset empties the store; word memory needs no clear.
module positional_sequence_store_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [31:0] o_read_value,
    output logic [1:0]  o_status,
    output logic [4:0]  o_element_count
);

    `include "positional_sequence_store_top_assert.svh"

    // command and status between controller and datapath
    pss_pkg::t_dp_cmd  dp_cmd;
    pss_pkg::t_dp_stat dp_stat;

    // Sequence the item: dispatch, take the word, move words, put, finish.
    pss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Hold the count, the item and the words; present the result.
    pss_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .o_strobe        (o_strobe),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    // A result only shows once the controller is back to idle.
    `PSS_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result while busy")

    // A taken item keeps the block busy in the next cycle.
    `PSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")

    // A flagged item never returns a word.
    `PSS_ASSERT_NOW(a_flag_zero, i_clk, i_rst_n, o_strobe && (o_status != pss_pkg::ST_OK), o_read_value == 32'd0, "flagged item returned data")

endmodule

### test/positional_sequence_store_top_tb.sv
// Testbench for positional_sequence_store_top: directed and random request traffic.
// Depends on pss_pkg and the RTL of the store; keeps a shadow copy of the sequence
// and checks each result strobe against it.
`timescale 1ns / 100ps

module positional_sequence_store_top_tb;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    // Drain past the longest busy stretch at the end.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 12;

    // Unused action code: the block must answer it with status ok and change nothing.
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam logic [4:0] POS_MAX    = 5'd31;

    typedef struct {
        logic [31:0]       read_value;
        pss_pkg::t_status  status;
        logic [4:0]        element_count;
    } t_seq_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [4:0]  i_position;
    logic [31:0] i_value;
    logic        o_strobe;
    logic [31:0] o_read_value;
    logic [1:0]  o_status;
    logic [4:0]  o_element_count;

    // Shadow of the store: the sequence, position 0 first, and its length.
    logic [31:0] shadow_words [DEPTH];
    int          shadow_count;

    // Results predicted for accepted items, oldest first.
    t_seq_result pending_results [$];
    int          error_count;

    // Sender pacing: items left in the current burst.
    int          burst_left;

    positional_sequence_store_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    always #5 i_clk = ~i_clk;

    // Insert a word at pos, shifting the later words up by one.
    function automatic pss_pkg::t_status shadow_insert(input int pos,
                                                       input logic [31:0] word);
        if (shadow_count >= DEPTH)
            return pss_pkg::ST_FULL;
        if (pos > shadow_count)
            return pss_pkg::ST_BAD_POS;
        for (int i = shadow_count; i > pos; i--)
            shadow_words[i] = shadow_words[i - 1];
        shadow_words[pos] = word;
        shadow_count++;
        return pss_pkg::ST_OK;
    endfunction

    // Remove the word at pos, shifting the later words down by one.
    function automatic pss_pkg::t_status shadow_remove(input int pos,
                                                       output logic [31:0] word);
        word = '0;
        if (shadow_count == 0)
            return pss_pkg::ST_EMPTY;
        if (pos >= shadow_count)
            return pss_pkg::ST_BAD_POS;
        word = shadow_words[pos];
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
        shadow_count--;
        return pss_pkg::ST_OK;
    endfunction

    // Apply one request to the shadow store and return the result it must produce.
    function automatic t_seq_result apply_request(input logic [2:0] act, input logic [4:0] pos,
                                                  input logic [31:0] word);
        t_seq_result res;
        logic [31:0] taken;
        res.read_value = '0;
        res.status     = pss_pkg::ST_OK;
        taken          = '0;
        case (act)
            pss_pkg::ACT_INS_AT:    res.status = shadow_insert(int'(pos), word);
            pss_pkg::ACT_INS_FRONT: res.status = shadow_insert(0, word);
            pss_pkg::ACT_INS_BACK:  res.status = shadow_insert(shadow_count, word);
            pss_pkg::ACT_DEL_AT:    res.status = shadow_remove(int'(pos), taken);
            pss_pkg::ACT_DEL_FRONT: res.status = shadow_remove(0, taken);
            pss_pkg::ACT_DEL_BACK: begin
                // An empty store reports empty, never a bad position.
                if (shadow_count == 0)
                    res.status = pss_pkg::ST_EMPTY;
                else
                    res.status = shadow_remove(shadow_count - 1, taken);
            end
            pss_pkg::ACT_READ_AT: begin
                if (int'(pos) < shadow_count)
                    taken = shadow_words[pos];
                else
                    res.status = pss_pkg::ST_BAD_POS;
            end
            default: ;
        endcase
        // Flagged requests and inserts carry a zero word.
        if (res.status == pss_pkg::ST_OK)
            res.read_value = taken;
        res.element_count = 5'(shadow_count);
        return res;
    endfunction

    // Offer one item, wait for the block to take it, record the expected result,
    // then pace the sender in bursts with random gaps between them.
    task automatic send_item(input logic [2:0] act, input logic [4:0] pos,
                             input logic [31:0] word);
        int gap;
        i_action   <= act;
        i_position <= pos;
        i_value    <= word;
        start      <= 1'b1;
        // Taken at the first edge that sees start high and busy low.
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(act, pos, word));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 19);
            // Keep about a quarter of the bursts back to back with no gap at all.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Requests on an empty store, and deleting the only word.
    task automatic test_empty_store;
        send_item(pss_pkg::ACT_READ_AT,   5'd0,    32'h0);
        send_item(pss_pkg::ACT_DEL_FRONT, 5'd0,    32'h0);
        send_item(pss_pkg::ACT_DEL_BACK,  5'd0,    32'h0);
        send_item(pss_pkg::ACT_DEL_AT,    POS_MAX, 32'h0);
        send_item(ACT_UNUSED,             POS_MAX, 32'hFFFF_FFFF);
        send_item(pss_pkg::ACT_INS_AT,    5'd1,    32'h1234_5678);
        send_item(pss_pkg::ACT_INS_FRONT, 5'd0,    32'hA5A5_5A5A);
        send_item(pss_pkg::ACT_DEL_AT,    5'd0,    32'h0);
    endtask

    // Fill to DEPTH words with every insert action, then hit the full store.
    task automatic test_fill_to_full;
        send_item(pss_pkg::ACT_INS_FRONT, 5'd0, 32'h0000_0000);
        send_item(pss_pkg::ACT_INS_BACK,  5'd0, 32'hFFFF_FFFF);
        send_item(pss_pkg::ACT_INS_AT,    5'd1, 32'h8000_0000);
        // Position equal to the count appends.
        send_item(pss_pkg::ACT_INS_AT,    5'd3, 32'h0000_0001);
        while (shadow_count < DEPTH)
            send_item(pss_pkg::ACT_INS_AT, 5'($urandom_range(0, shadow_count)), $urandom);
        // Full wins over a bad position.
        send_item(pss_pkg::ACT_INS_AT,    POS_MAX, 32'hDEAD_BEEF);
        send_item(pss_pkg::ACT_INS_BACK,  5'd0,    32'hDEAD_BEEF);
        send_item(pss_pkg::ACT_READ_AT,   5'd15,   32'h0);
        send_item(pss_pkg::ACT_READ_AT,   5'd16,   32'h0);
        send_item(pss_pkg::ACT_DEL_AT,    5'd15,   32'h0);
        send_item(pss_pkg::ACT_DEL_FRONT, 5'd0,    32'h0);
        send_item(pss_pkg::ACT_DEL_BACK,  5'd0,    32'h0);
    endtask

    // Random traffic in phases that lean toward filling, balance or draining.
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          ins_weight;
        int          roll;
        logic [2:0]  act;
        logic [4:0]  pos;
        logic [31:0] word;
        sent       = 0;
        ins_weight = 42;
        while (sent < n_items) begin
            if (sent % 80 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_weight = 25;
                    1:       ins_weight = 42;
                    default: ins_weight = 60;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                act = pss_pkg::ACT_READ_AT;
            end else if (roll < 15 + ins_weight) begin
                case ($urandom_range(0, 2))
                    0:       act = pss_pkg::ACT_INS_AT;
                    1:       act = pss_pkg::ACT_INS_FRONT;
                    default: act = pss_pkg::ACT_INS_BACK;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       act = pss_pkg::ACT_DEL_AT;
                    1:       act = pss_pkg::ACT_DEL_FRONT;
                    default: act = pss_pkg::ACT_DEL_BACK;
                endcase
            end
            // Sprinkle in the unused code now and then; it does not count as traffic.
            if ($urandom_range(0, 49) == 0)
                act = ACT_UNUSED;
            // Mostly positions up to the count (the count itself is the edge case),
            // sometimes anywhere in the field.
            if ($urandom_range(0, 99) < 85)
                pos = 5'($urandom_range(0, shadow_count));
            else
                pos = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 9))
                0:       word = 32'h0;
                1:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_item(act, pos, word);
            if (act != ACT_UNUSED)
                sent++;
        end
    endtask

    // Compare each result strobe with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_seq_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending: read_value %h status %0d count %0d",
                         $time, o_read_value, o_status, o_element_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, o_read_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_element_count !== want.element_count) begin
                    $display("%0t: element_count expected %0d actual %0d",
                             $time, want.element_count, o_element_count);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run.
    initial begin
        #5_000_000;
        $display("positional_sequence_store_top_tb NOT OK");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= '0;
        i_position   <= '0;
        i_value      <= '0;
        error_count  = 0;
        shadow_count = 0;
        burst_left   = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_words[i] = '0;

        // Hold reset low, then release it on an edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_fill_to_full();
        test_random_traffic(1000);
        start <= 1'b0;

        // Drain the outstanding results, then watch for stray strobes.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("positional_sequence_store_top_tb OK");
        else
            $display("positional_sequence_store_top_tb NOT OK");
        $finish;
    end

endmodule

### positional_sequence_store_top.f
+incdir+rtl/core
rtl/core/pss_pkg.sv
rtl/core/pss_ram.sv
rtl/core/pss_ctrl.sv
rtl/core/pss_datapath.sv
rtl/core/positional_sequence_store_top.sv
test/positional_sequence_store_top_tb.sv
